### hdl/bsfr_pkg.sv
// Shared constants for the byte-stuffed frame receiver.
`default_nettype none
package bsfr_pkg;

	// Default ring geometry
	localparam int NUM_FRAMES_DEF  = 8;
	localparam int FRAME_BYTES_DEF = 256;

	// Stream field widths
	localparam int CMD_W    = 2;
	localparam int BYTE_W   = 8;
	localparam int WANT_W   = 16;
	localparam int FW_W     = 4;
	localparam int IN_DW    = 32;
	localparam int OUT_DW   = 24;

	// Configuration port
	localparam int APB_AW = 4;
	localparam int APB_DW = 32;

	// Request commands
	localparam logic [CMD_W-1:0] CMD_LINE = 2'd0;
	localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
	localparam logic [CMD_W-1:0] CMD_POP  = 2'd2;
	localparam logic [CMD_W-1:0] CMD_NOP  = 2'd3;

	// Register indexes (paddr[3:2])
	localparam logic [1:0] REG_ESCAPE = 2'd0;
	localparam logic [1:0] REG_START  = 2'd1;
	localparam logic [1:0] REG_STOP   = 2'd2;

	// Register reset values
	localparam logic [BYTE_W-1:0] ESCAPE_RST = 8'h10;
	localparam logic [BYTE_W-1:0] START_RST  = 8'h02;
	localparam logic [BYTE_W-1:0] STOP_RST   = 8'h03;

endpackage
`default_nettype wire

### hdl/bsfr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bsfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  wire                       clk,
	input  wire                       we,
	input  wire [$clog2(DEPTH)-1:0]   waddr,
	input  wire [WIDTH-1:0]           wdata,
	input  wire                       re,
	input  wire [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]          rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds while re is low
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

### hdl/byte_stuffed_frame_receiver_top.sv
// Byte-stuffed frame receiver: escape parser, frame ring and read-out path.
//
// Requests enter on the s_axis channel: tuser carries the command (received
// line byte, read head frame byte, pop head frame, no-op), tdata the line
// byte, byte offset and wanted length. Each request yields exactly one
// result on m_axis with the frame count, read byte, popped length and the
// completed / discarded / dropped flags.
// The accept edge updates the parser and ring state and launches the frame
// store and length RAM reads into the read stage; the read stage then moves
// the result into the output register, which raises m_axis_tvalid, as soon
// as that register is empty or its result is being taken.
// One request is accepted every cycle while results are taken downstream;
// throughput is set by the parser update and the one read port of each RAM.
// If the downstream side stalls, the output register and the RAM read
// stage hold and s_axis_tready drops once both are full; no result is lost.
// Reset empties the ring, puts the parser into sync and loads the default
// escape, start and stop codes; frame contents are not cleared (no pass).
// The APB port writes and reads the three code registers at 0x0, 0x4, 0x8,
// and should only be written while no request is in flight.
`default_nettype none
module byte_stuffed_frame_receiver_top #(
	parameter int NUM_FRAMES  = bsfr_pkg::NUM_FRAMES_DEF,
	parameter int FRAME_BYTES = bsfr_pkg::FRAME_BYTES_DEF
) (
	input  wire                          clk,
	input  wire                          arst_n,
	// Request stream
	input  wire                          s_axis_tvalid,
	output logic                         s_axis_tready,
	// [7:0] line_byte, [15:8] byte_offset, [31:16] wanted_length
	input  wire [bsfr_pkg::IN_DW-1:0]    s_axis_tdata,
	// [1:0] command
	input  wire [bsfr_pkg::CMD_W-1:0]    s_axis_tuser,
	// Result stream
	output logic                         m_axis_tvalid,
	input  wire                          m_axis_tready,
	// [3:0] frames_waiting, [11:4] head_byte, [19:12] popped_length,
	// [20] frame_completed, [21] frame_discarded, [22] byte_dropped, [23] zero
	output logic [bsfr_pkg::OUT_DW-1:0]  m_axis_tdata,
	// Configuration port
	input  wire                          psel,
	input  wire                          penable,
	input  wire                          pwrite,
	input  wire [bsfr_pkg::APB_AW-1:0]   paddr,
	input  wire [bsfr_pkg::APB_DW-1:0]   pwdata,
	output logic [bsfr_pkg::APB_DW-1:0]  prdata,
	output logic                         pready
);

	import bsfr_pkg::*;

	localparam int SLOT_W   = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int CNT_W    = $clog2(NUM_FRAMES + 1);
	localparam int POS_W    = $clog2(FRAME_BYTES);
	localparam int STORE_D  = NUM_FRAMES * FRAME_BYTES;
	localparam int STORE_AW = $clog2(STORE_D);

	localparam logic [SLOT_W-1:0]   LAST_SLOT = SLOT_W'(NUM_FRAMES - 1);
	localparam logic [CNT_W-1:0]    FULL_CNT  = CNT_W'(NUM_FRAMES);
	localparam logic [POS_W-1:0]    LAST_POS  = POS_W'(FRAME_BYTES - 1);
	localparam logic [STORE_AW-1:0] SLOT_SPAN = STORE_AW'(FRAME_BYTES);

	// Parser states
	localparam logic [1:0] PS_SYNC     = 2'd0;
	localparam logic [1:0] PS_SYNC_ESC = 2'd1;
	localparam logic [1:0] PS_DATA     = 2'd2;
	localparam logic [1:0] PS_DATA_ESC = 2'd3;

	// Configuration registers
	logic [BYTE_W-1:0] esc_q, start_q, stop_q;
	logic              cfg_wr;

	// Parser and ring state
	logic [1:0]        parser_q, parser_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [SLOT_W-1:0] wslot_q, wslot_d, rslot_q, rslot_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic              comp_d, disc_d, drop_d, store_en;

	// Request fields
	logic              acc;
	logic [CMD_W-1:0]  cmd;
	logic [BYTE_W-1:0] line_byte, byte_offset;
	logic [WANT_W-1:0] wanted_length;
	logic              full;

	// RAM ports
	logic [STORE_AW-1:0] st_waddr, st_raddr;
	logic [BYTE_W-1:0]   st_rdata;
	logic [POS_W-1:0]    len_rdata;

	// Read stage
	logic              valid_s1;
	logic [CMD_W-1:0]  cmd_s1;
	logic [BYTE_W-1:0] off_s1;
	logic [WANT_W-1:0] want_s1;
	logic [CNT_W-1:0]  cnt_s1;
	logic              have_s1, comp_s1, disc_s1, drop_s1;
	logic              move_s1;
	logic [BYTE_W-1:0] head_s1, popped_s1;
	logic [WANT_W-1:0] len_ext, min_len;

	// Output register
	logic              out_valid_q;
	logic [OUT_DW-1:0] out_data_q;

	// ---------------- Configuration port ----------------
	assign pready = 1'b1;
	assign cfg_wr = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q   <= ESCAPE_RST;
			start_q <= START_RST;
			stop_q  <= STOP_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_ESCAPE: esc_q   <= pwdata[BYTE_W-1:0];
				REG_START:  start_q <= pwdata[BYTE_W-1:0];
				REG_STOP:   stop_q  <= pwdata[BYTE_W-1:0];
				default:    ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ESCAPE: prdata = APB_DW'(esc_q);
			REG_START:  prdata = APB_DW'(start_q);
			REG_STOP:   prdata = APB_DW'(stop_q);
			default:    prdata = '0;
		endcase
	end

	// ---------------- Request decode ----------------
	assign acc           = s_axis_tvalid & s_axis_tready;
	assign cmd           = s_axis_tuser;
	assign line_byte     = s_axis_tdata[7:0];
	assign byte_offset   = s_axis_tdata[15:8];
	assign wanted_length = s_axis_tdata[31:16];
	assign full          = (cnt_q == FULL_CNT);

	// ---------------- Parser and ring update ----------------
	always_comb begin
		parser_d = parser_q;
		pos_d    = pos_q;
		wslot_d  = wslot_q;
		rslot_d  = rslot_q;
		cnt_d    = cnt_q;
		comp_d   = 1'b0;
		disc_d   = 1'b0;
		drop_d   = 1'b0;
		store_en = 1'b0;
		if (acc) begin
			case (cmd)
				CMD_LINE: begin
					if (full) begin
						drop_d = 1'b1;
					end else begin
						case (parser_q)
							PS_SYNC: begin
								if (line_byte == esc_q) parser_d = PS_SYNC_ESC;
							end
							PS_SYNC_ESC: begin
								if (line_byte == start_q) begin
									pos_d    = '0;
									parser_d = PS_DATA;
								end else begin
									parser_d = PS_SYNC;
								end
							end
							PS_DATA: begin
								if (line_byte == esc_q) parser_d = PS_DATA_ESC;
								else store_en = 1'b1;
							end
							default: begin
								// doubled escape is a literal, checked before stop
								if (line_byte == esc_q) begin
									parser_d = PS_DATA;
									store_en = 1'b1;
								end else if (line_byte == stop_q) begin
									wslot_d  = (wslot_q == LAST_SLOT) ? '0 : wslot_q + 1'b1;
									cnt_d    = cnt_q + 1'b1;
									pos_d    = '0;
									parser_d = PS_SYNC;
									comp_d   = 1'b1;
								end else begin
									pos_d    = '0;
									parser_d = PS_SYNC;
									disc_d   = 1'b1;
								end
							end
						endcase
						// payload byte: slot overflow drops the frame and resyncs
						if (store_en) begin
							if (pos_q == LAST_POS) begin
								pos_d    = '0;
								parser_d = PS_SYNC;
								disc_d   = 1'b1;
							end else begin
								pos_d = pos_q + 1'b1;
							end
						end
					end
				end
				CMD_POP: begin
					if (wanted_length != '0 && cnt_q != '0) begin
						rslot_d = (rslot_q == LAST_SLOT) ? '0 : rslot_q + 1'b1;
						cnt_d   = cnt_q - 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			parser_q <= PS_SYNC;
			pos_q    <= '0;
			wslot_q  <= '0;
			rslot_q  <= '0;
			cnt_q    <= '0;
		end else begin
			parser_q <= parser_d;
			pos_q    <= pos_d;
			wslot_q  <= wslot_d;
			rslot_q  <= rslot_d;
			cnt_q    <= cnt_d;
		end
	end

	// ---------------- Frame store and length table ----------------
	assign st_waddr = STORE_AW'(wslot_q) * SLOT_SPAN + STORE_AW'(pos_q);
	assign st_raddr = STORE_AW'(rslot_q) * SLOT_SPAN + STORE_AW'(POS_W'(byte_offset));

	bsfr_ram #(
		.WIDTH (BYTE_W),
		.DEPTH (STORE_D)
	) u_store (
		.clk   (clk),
		.we    (store_en),
		.waddr (st_waddr),
		.wdata (line_byte),
		.re    (acc),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	bsfr_ram #(
		.WIDTH (POS_W),
		.DEPTH (NUM_FRAMES)
	) u_len (
		.clk   (clk),
		.we    (comp_d),
		.waddr (wslot_q),
		.wdata (pos_q),
		.re    (acc),
		.raddr (rslot_q),
		.rdata (len_rdata)
	);

	// ---------------- Read stage ----------------
	assign move_s1       = valid_s1 & (~out_valid_q | m_axis_tready);
	assign s_axis_tready = ~valid_s1 | move_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (move_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			cmd_s1  <= cmd;
			off_s1  <= byte_offset;
			want_s1 <= wanted_length;
			cnt_s1  <= cnt_d;
			have_s1 <= (cnt_q != '0);
			comp_s1 <= comp_d;
			disc_s1 <= disc_d;
			drop_s1 <= drop_d;
		end
	end

	// head byte only below the frame length, pop hands out min(wanted, length)
	assign len_ext = WANT_W'(len_rdata);
	assign min_len = (want_s1 < len_ext) ? want_s1 : len_ext;

	always_comb begin
		head_s1   = '0;
		popped_s1 = '0;
		case (cmd_s1)
			CMD_READ: begin
				if (have_s1 && (WANT_W'(off_s1) < len_ext)) head_s1 = st_rdata;
			end
			CMD_POP: begin
				if (have_s1 && want_s1 != '0) popped_s1 = min_len[BYTE_W-1:0];
			end
			default: ;
		endcase
	end

	// ---------------- Output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_data_q <= {1'b0, drop_s1, disc_s1, comp_s1, popped_s1, head_s1,
				FW_W'(cnt_s1)};
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	// ---------------- Assertions ----------------
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= FULL_CNT)
		else $error("frame count beyond ring depth");

	a_ring_slots: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == FULL_CNT) |-> (wslot_q == rslot_q))
		else $error("ring slots disagree with frame count");

	a_complete_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		comp_d |=> (cnt_q == $past(cnt_q) + 1'b1))
		else $error("completed frame not counted");

	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && drop_s1) |-> (cnt_s1 == FULL_CNT))
		else $error("byte dropped with room in the ring");

endmodule
`default_nettype wire
